>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> src/olst_pkg.sv
// ----------------------------------------------------------------------------
// olst_pkg
// Types, codes and field layout shared by the ordered array list block.
// ----------------------------------------------------------------------------
package olst_pkg;

  // Default number of list cells.
  localparam int unsigned DefCapacity = 8;

  // Field widths.
  localparam int unsigned CmdW    = 2;
  localparam int unsigned PosW    = 3;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 4;

  // Stream data widths, padded to whole bytes.
  localparam int unsigned InDataW  = ((CmdW + PosW + ValW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((StatusW + ValW + CountW + 7) / 8) * 8;

  // Input field offsets.
  localparam int unsigned InCmdLsb = 0;
  localparam int unsigned InPosLsb = InCmdLsb + CmdW;
  localparam int unsigned InValLsb = InPosLsb + PosW;

  // Output field offsets.
  localparam int unsigned OutStatusLsb = 0;
  localparam int unsigned OutValLsb    = OutStatusLsb + StatusW;
  localparam int unsigned OutCountLsb  = OutValLsb + ValW;
  localparam int unsigned OutUsedW     = OutCountLsb + CountW;

  // Command codes.
  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } olst_cmd_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } olst_status_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } olst_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // Register the incoming request.
    logic execute;  // Apply the request to the cells and load the result.
  } olst_ctrl_t;

endpackage

>>> src/ordered_array_list.sv
// ----------------------------------------------------------------------------
// ordered_array_list
// Fixed-capacity ordered list of signed words with insert, delete and read.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: command, position and value packed
//   in s_axis_tdata. Every request returns exactly one result on the m_axis
//   channel: status, read value and the entry count after the request.
//   A request is first registered; then the whole cell row shifts in
//   parallel and the result register is loaded. Execution waits while an
//   earlier result is still untaken, and no new request is accepted until
//   the current one has executed.
//   While a result waits, the next request is still accepted and registered;
//   it is executed as soon as the waiting result is taken, so a stalled
//   receiver holds the block after at most one further request.
//   Reset empties the list and clears both handshake sides; cell contents
//   are not cleared, as no cell at or past the count is ever read.
//   Refused requests (list full, list empty, position out of range or an
//   unknown command) leave the list unchanged and return a read value of 0.
// ----------------------------------------------------------------------------
module ordered_array_list #(
  parameter int unsigned CAPACITY = olst_pkg::DefCapacity
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: command[1:0], position[4:2], value[36:5], zero pad.
  input  logic [olst_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: status[1:0], read_value[33:2], count[37:34], zero pad.
  output logic [olst_pkg::OutDataW-1:0] m_axis_tdata
);

  olst_pkg::olst_ctrl_t                 ctrl;
  logic [olst_pkg::StatusW-1:0]         status;
  logic signed [olst_pkg::ValW-1:0]     read_value;
  logic [olst_pkg::CountW-1:0]          count;

  // Sequencing of capture and execution.
  olst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (ctrl)
  );

  // List cells and result payload.
  olst_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .command_i    (s_axis_tdata[olst_pkg::InCmdLsb +: olst_pkg::CmdW]),
    .position_i   (s_axis_tdata[olst_pkg::InPosLsb +: olst_pkg::PosW]),
    .value_i      (s_axis_tdata[olst_pkg::InValLsb +: olst_pkg::ValW]),
    .status_o     (status),
    .read_value_o (read_value),
    .count_o      (count)
  );

  // Output packing with zero pad.
  assign m_axis_tdata = olst_pkg::OutDataW'({count, read_value, status});

endmodule

>>> src/olst_ctrl.sv
// ----------------------------------------------------------------------------
// olst_ctrl
// Controller: sequences capture and execution of one request at a time and
// owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module olst_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output olst_pkg::olst_ctrl_t ctrl_o
);

  olst_pkg::olst_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  can_load;

  // The result register can be loaded when empty or being drained.
  assign can_load = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      olst_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = olst_pkg::ST_EXEC;
      end
      olst_pkg::ST_EXEC: begin
        if (can_load) state_d = olst_pkg::ST_IDLE;
      end
      default: state_d = olst_pkg::ST_IDLE;
    endcase
  end

  // Outputs to the ports and the datapath.
  always_comb begin
    in_ready_o     = 1'b0;
    ctrl_o.capture = 1'b0;
    ctrl_o.execute = 1'b0;
    case (state_q)
      olst_pkg::ST_IDLE: begin
        in_ready_o     = 1'b1;
        ctrl_o.capture = in_valid_i;
      end
      olst_pkg::ST_EXEC: begin
        ctrl_o.execute = can_load;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Result valid flag: set on a load, cleared when the receiver takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (ctrl_o.execute) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olst_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> src/olst_datapath.sv
// ----------------------------------------------------------------------------
// olst_datapath
// Datapath: request register, a row of list cells that shifts as a whole,
// the fill count and the result register.
// ----------------------------------------------------------------------------
module olst_datapath #(
  parameter int unsigned CAPACITY = olst_pkg::DefCapacity
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  olst_pkg::olst_ctrl_t                 ctrl_i,
  input  logic [olst_pkg::CmdW-1:0]            command_i,
  input  logic [olst_pkg::PosW-1:0]            position_i,
  input  logic signed [olst_pkg::ValW-1:0]     value_i,
  output logic [olst_pkg::StatusW-1:0]         status_o,
  output logic signed [olst_pkg::ValW-1:0]     read_value_o,
  output logic [olst_pkg::CountW-1:0]          count_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > olst_pkg::PosW) ? CntW : olst_pkg::PosW;

  // Request register.
  logic [olst_pkg::CmdW-1:0]        cmd_q;
  logic [olst_pkg::PosW-1:0]        pos_q;
  logic signed [olst_pkg::ValW-1:0] val_q;

  // List state.
  logic [olst_pkg::ValW-1:0] cell_q [CAPACITY];
  logic [olst_pkg::ValW-1:0] cell_d [CAPACITY];
  logic [CntW-1:0]           cnt_q, cnt_d;

  // Result register.
  logic [olst_pkg::StatusW-1:0]     status_q, status_d;
  logic signed [olst_pkg::ValW-1:0] rdval_q, rdval_d;
  logic [olst_pkg::CountW-1:0]      count_q;

  logic [CmpW-1:0] pos_c, cnt_c;
  logic            is_full, is_empty, do_insert, do_delete;
  logic [olst_pkg::ValW-1:0] sel_value;

  assign pos_c    = CmpW'(pos_q);
  assign cnt_c    = CmpW'(cnt_q);
  assign is_full  = (cnt_q == CntW'(CAPACITY));
  assign is_empty = (cnt_q == '0);

  // Status decode and count update.
  always_comb begin
    status_d  = olst_pkg::STAT_OK;
    do_insert = 1'b0;
    do_delete = 1'b0;
    case (cmd_q)
      olst_pkg::CMD_INSERT: begin
        if (is_full)            status_d = olst_pkg::STAT_FULL;
        else if (pos_c > cnt_c) status_d = olst_pkg::STAT_RANGE;
        else                    do_insert = 1'b1;
      end
      olst_pkg::CMD_DELETE: begin
        if (is_empty)            status_d = olst_pkg::STAT_EMPTY;
        else if (pos_c >= cnt_c) status_d = olst_pkg::STAT_RANGE;
        else                     do_delete = 1'b1;
      end
      olst_pkg::CMD_READ: begin
        if (is_empty)            status_d = olst_pkg::STAT_EMPTY;
        else if (pos_c >= cnt_c) status_d = olst_pkg::STAT_RANGE;
      end
      default: status_d = olst_pkg::STAT_RANGE;
    endcase

    cnt_d = cnt_q;
    if (do_insert) cnt_d = cnt_q + CntW'(1);
    if (do_delete) cnt_d = cnt_q - CntW'(1);
  end

  // Read selection over the cells.
  always_comb begin
    sel_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CmpW'(i) == pos_c) sel_value = cell_q[i];
    end
  end

  assign rdval_d = (cmd_q == olst_pkg::CMD_READ && status_d == olst_pkg::STAT_OK)
                   ? sel_value : '0;

  // Per-cell next value: each cell looks only at its two neighbors.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [olst_pkg::ValW-1:0] from_below, from_above;

    if (g > 0) begin : g_below
      assign from_below = cell_q[g-1];
    end else begin : g_no_below
      assign from_below = cell_q[g];
    end

    if (g < CAPACITY - 1) begin : g_above
      assign from_above = cell_q[g+1];
    end else begin : g_no_above
      assign from_above = cell_q[g];
    end

    always_comb begin
      cell_d[g] = cell_q[g];
      if (do_insert) begin
        if (CmpW'(g) == pos_c) cell_d[g] = val_q;
        else if (CmpW'(g) > pos_c && CmpW'(g) <= cnt_c) cell_d[g] = from_below;
      end else if (do_delete) begin
        if (CmpW'(g) >= pos_c && (CmpW'(g) + CmpW'(1)) < cnt_c) cell_d[g] = from_above;
      end
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= command_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
  end

  // Cell row and result payload.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.execute) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cell_q[i] <= cell_d[i];
      end
      status_q <= status_d;
      rdval_q  <= rdval_d;
      count_q  <= olst_pkg::CountW'(cnt_d);
    end
  end

  // Fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.execute) begin
      cnt_q <= cnt_d;
    end
  end

  assign status_o     = status_q;
  assign read_value_o = rdval_q;
  assign count_o      = count_q;

endmodule

>>> src/olst_checker.sv
// ----------------------------------------------------------------------------
// olst_checker
// Port-level checks on the ordered array list, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module olst_checker #(
  parameter int unsigned CAPACITY = olst_pkg::DefCapacity
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [olst_pkg::OutDataW-1:0] m_axis_tdata
);

  logic                         in_fire, stall;
  logic [olst_pkg::StatusW-1:0] status;
  logic [olst_pkg::ValW-1:0]    read_value;
  logic [olst_pkg::CountW-1:0]  count;
  logic                         big_capacity;

  assign in_fire      = s_axis_tvalid && s_axis_tready;
  assign stall        = m_axis_tvalid && !m_axis_tready;
  assign status       = m_axis_tdata[olst_pkg::OutStatusLsb +: olst_pkg::StatusW];
  assign read_value   = m_axis_tdata[olst_pkg::OutValLsb +: olst_pkg::ValW];
  assign count        = m_axis_tdata[olst_pkg::OutCountLsb +: olst_pkg::CountW];
  assign big_capacity = (CAPACITY > 15);

  // A stalled result holds its payload.
  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, stall, m_axis_tvalid && $stable(m_axis_tdata))

  // An accepted request makes the block busy in the next cycle.
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_fire, !s_axis_tready)

  // A refused request never returns data.
  `ASSERT_IMPLIES(a_refused_zero, clk_i, rst_ni,
    m_axis_tvalid && status != olst_pkg::STAT_OK, read_value == '0)

  // For capacities up to 15, the reported count never exceeds the capacity.
  `ASSERT_IMPLIES(a_count_bound, clk_i, rst_ni,
    m_axis_tvalid && !big_capacity, 32'(count) <= CAPACITY)

endmodule

bind ordered_array_list olst_checker #(
  .CAPACITY (CAPACITY)
) u_olst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
